// File: hw/rtl/xenc_pkg.sv
// Package for the x86-64 instruction encoder: payload words, form codes and
// the structure that passes an instruction layout from decode to packing.
// Depends on nothing.
package xenc_pkg;

    // Instruction forms carried in the cmd field.
    typedef enum logic [3:0] {
        CMD_CALL     = 4'd0,
        CMD_RET      = 4'd1,
        CMD_MOV_IMM  = 4'd2,
        CMD_MOV_RR   = 4'd3,
        CMD_LOAD     = 4'd4,
        CMD_STORE    = 4'd5,
        CMD_LEA      = 4'd6,
        CMD_SHL      = 4'd7,
        CMD_ADD_IMM  = 4'd8,
        CMD_AND_IMM  = 4'd9,
        CMD_ADD_RR   = 4'd10,
        CMD_OR_RR    = 4'd11,
        CMD_PUSH_R   = 4'd12,
        CMD_PUSH_IMM = 4'd13,
        CMD_POP      = 4'd14,
        CMD_SYSCALL  = 4'd15
    } t_cmd;

    // Slots of the instruction header, in emission order.
    localparam int HDR_SLOTS = 7;
    localparam int SLOT_P66  = 0;
    localparam int SLOT_P67  = 1;
    localparam int SLOT_REX  = 2;
    localparam int SLOT_OP1  = 3;
    localparam int SLOT_OP2  = 4;
    localparam int SLOT_MODRM = 5;
    localparam int SLOT_SIB  = 6;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [6:0]  reg_a;
        logic [6:0]  reg_b;
        logic [63:0] imm;
        logic [31:0] disp;
    } t_enc_req;

    typedef struct packed {
        logic [63:0] bytes_low;
        logic [63:0] bytes_high;
        logic [3:0]  byte_count;
    } t_enc_rsp;

    // Layout of one instruction: optional header bytes and a little-endian tail.
    typedef struct packed {
        logic [HDR_SLOTS-1:0]      hdr_vld;
        logic [HDR_SLOTS-1:0][7:0] hdr_byte;
        logic [63:0]               tail_val;
        logic [3:0]                tail_len;
    } t_enc_layout;

endpackage

// File: hw/rtl/xenc_decode.sv
// Instruction form decoder: turns one request word into the header bytes
// and the immediate or displacement tail of the instruction.
// Depends on xenc_pkg.
module xenc_decode (
    input  xenc_pkg::t_enc_req    i_req,
    output xenc_pkg::t_enc_layout o_layout
);
    import xenc_pkg::*;

    function automatic logic [1:0] rsz(input logic [6:0] d);
        return d[5:4];
    endfunction

    function automatic logic [3:0] imm_len(input logic [1:0] s, input logic wide64);
        logic [3:0] n;
        unique case (s)
            2'd0: n = 4'd1;
            2'd1: n = 4'd2;
            2'd2: n = 4'd4;
            2'd3: n = wide64 ? 4'd8 : 4'd4;
        endcase
        return n;
    endfunction

    logic [6:0]  opr;
    logic [6:0]  base;
    logic [6:0]  rmr;
    logic [6:0]  regr;
    logic [6:0]  wreg;
    logic        rex_w;
    logic        full_a;
    logic        full_b;
    logic [63:0] k32;
    logic [2:0]  digit;
    logic [7:0]  acc_op;

    assign full_a = rsz(i_req.reg_a) != 2'd0;
    assign full_b = rsz(i_req.reg_b) != 2'd0;
    assign k32    = {32'd0, i_req.imm[31:0]};

    always_comb begin
        opr      = '0;
        base     = '0;
        rmr      = '0;
        regr     = '0;
        wreg     = '0;
        digit    = 3'd0;
        acc_op   = 8'h04;
        o_layout = '0;

        unique case (t_cmd'(i_req.cmd))
            CMD_CALL: begin
                o_layout.hdr_vld[SLOT_OP1]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP1] = 8'hE8;
                o_layout.tail_val = k32;
                o_layout.tail_len = 4'd4;
            end
            CMD_RET: begin
                o_layout.hdr_vld[SLOT_OP1]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP1] = 8'hC3;
            end
            CMD_MOV_IMM: begin
                opr  = i_req.reg_a;
                rmr  = i_req.reg_a;
                wreg = i_req.reg_a;
                o_layout.hdr_vld[SLOT_OP1]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP1] = (full_a ? 8'hB8 : 8'hB0)
                                              | {5'd0, i_req.reg_a[2:0]};
                o_layout.tail_val = i_req.imm;
                o_layout.tail_len = imm_len(rsz(i_req.reg_a), 1'b1);
            end
            CMD_MOV_RR, CMD_ADD_RR, CMD_OR_RR: begin
                opr  = i_req.reg_b;
                rmr  = i_req.reg_a;
                regr = i_req.reg_b;
                wreg = i_req.reg_b;
                o_layout.hdr_vld[SLOT_OP1]   = 1'b1;
                o_layout.hdr_vld[SLOT_MODRM] = 1'b1;
                o_layout.hdr_byte[SLOT_MODRM] = {2'd3, i_req.reg_b[2:0], i_req.reg_a[2:0]};
                if (t_cmd'(i_req.cmd) == CMD_MOV_RR) begin
                    o_layout.hdr_byte[SLOT_OP1] = full_a ? 8'h89 : 8'h88;
                end else if (t_cmd'(i_req.cmd) == CMD_ADD_RR) begin
                    o_layout.hdr_byte[SLOT_OP1] = full_a ? 8'h01 : 8'h00;
                end else begin
                    o_layout.hdr_byte[SLOT_OP1] = full_a ? 8'h09 : 8'h08;
                end
            end
            CMD_LOAD, CMD_STORE, CMD_LEA: begin
                opr  = i_req.reg_b;
                base = i_req.reg_a;
                rmr  = i_req.reg_a;
                regr = i_req.reg_b;
                wreg = i_req.reg_b;
                o_layout.hdr_vld[SLOT_OP1]   = 1'b1;
                o_layout.hdr_vld[SLOT_MODRM] = 1'b1;
                if (t_cmd'(i_req.cmd) == CMD_LOAD) begin
                    o_layout.hdr_byte[SLOT_OP1] = full_b ? 8'h8B : 8'h8A;
                end else if (t_cmd'(i_req.cmd) == CMD_STORE) begin
                    o_layout.hdr_byte[SLOT_OP1] = full_b ? 8'h89 : 8'h88;
                end else begin
                    o_layout.hdr_byte[SLOT_OP1] = 8'h8D;
                end
                o_layout.hdr_byte[SLOT_SIB] = 8'h24;
                if (i_req.reg_a[2:0] == 3'd4 && i_req.disp == 32'd0) begin
                    // Stack-pointer base without displacement needs only the SIB.
                    o_layout.hdr_byte[SLOT_MODRM] = {2'd0, i_req.reg_b[2:0], 3'd4};
                    o_layout.hdr_vld[SLOT_SIB]    = 1'b1;
                end else begin
                    o_layout.hdr_byte[SLOT_MODRM] = {2'd2, i_req.reg_b[2:0], i_req.reg_a[2:0]};
                    o_layout.hdr_vld[SLOT_SIB]    = i_req.reg_a[2:0] == 3'd4;
                    o_layout.tail_val = {32'd0, i_req.disp};
                    o_layout.tail_len = 4'd4;
                end
            end
            CMD_SHL: begin
                opr  = i_req.reg_a;
                rmr  = i_req.reg_a;
                wreg = i_req.reg_a;
                o_layout.hdr_vld[SLOT_OP1]    = 1'b1;
                o_layout.hdr_byte[SLOT_OP1]   = full_a ? 8'hC1 : 8'hC0;
                o_layout.hdr_vld[SLOT_MODRM]  = 1'b1;
                o_layout.hdr_byte[SLOT_MODRM] = {2'd3, 3'd4, i_req.reg_a[2:0]};
                o_layout.tail_val = i_req.imm;
                o_layout.tail_len = 4'd1;
            end
            CMD_ADD_IMM, CMD_AND_IMM: begin
                opr  = i_req.reg_a;
                rmr  = i_req.reg_a;
                wreg = i_req.reg_a;
                if (t_cmd'(i_req.cmd) == CMD_AND_IMM) begin
                    digit  = 3'd4;
                    acc_op = 8'h24;
                end
                o_layout.hdr_vld[SLOT_OP1] = 1'b1;
                o_layout.tail_val = k32;
                o_layout.hdr_byte[SLOT_MODRM] = {2'd3, digit, i_req.reg_a[2:0]};
                if (i_req.reg_a[3:0] == 4'd0) begin
                    // Accumulator short form, no ModRM.
                    o_layout.hdr_byte[SLOT_OP1] = acc_op + {7'd0, full_a};
                    o_layout.tail_len = imm_len(rsz(i_req.reg_a), 1'b0);
                end else if (full_a && i_req.imm[31:0] < 32'd128) begin
                    o_layout.hdr_byte[SLOT_OP1]  = 8'h83;
                    o_layout.hdr_vld[SLOT_MODRM] = 1'b1;
                    o_layout.tail_len = 4'd1;
                end else begin
                    o_layout.hdr_byte[SLOT_OP1]  = full_a ? 8'h81 : 8'h80;
                    o_layout.hdr_vld[SLOT_MODRM] = 1'b1;
                    o_layout.tail_len = imm_len(rsz(i_req.reg_a), 1'b0);
                end
            end
            CMD_PUSH_R, CMD_POP: begin
                opr = i_req.reg_a;
                rmr = i_req.reg_a;
                o_layout.hdr_vld[SLOT_OP1]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP1] =
                    (t_cmd'(i_req.cmd) == CMD_POP ? 8'h58 : 8'h50) | {5'd0, i_req.reg_a[2:0]};
            end
            CMD_PUSH_IMM: begin
                o_layout.hdr_vld[SLOT_OP1] = 1'b1;
                o_layout.tail_val = k32;
                if (i_req.imm[31:0] < 32'd128) begin
                    o_layout.hdr_byte[SLOT_OP1] = 8'h6A;
                    o_layout.tail_len = 4'd1;
                end else begin
                    o_layout.hdr_byte[SLOT_OP1] = 8'h68;
                    o_layout.tail_len = 4'd4;
                end
            end
            CMD_SYSCALL: begin
                o_layout.hdr_vld[SLOT_OP1]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP1] = 8'h0F;
                o_layout.hdr_vld[SLOT_OP2]  = 1'b1;
                o_layout.hdr_byte[SLOT_OP2] = 8'h05;
            end
        endcase

        // Prefixes and REX follow from the register roles picked above.
        rex_w = rsz(wreg) == 2'd3;
        o_layout.hdr_vld[SLOT_P66]  = rsz(opr) == 2'd1;
        o_layout.hdr_byte[SLOT_P66] = 8'h66;
        o_layout.hdr_vld[SLOT_P67]  = rsz(base) == 2'd2;
        o_layout.hdr_byte[SLOT_P67] = 8'h67;
        o_layout.hdr_vld[SLOT_REX]  = rmr[3] | regr[3] | rex_w | rmr[6] | regr[6] | wreg[6];
        o_layout.hdr_byte[SLOT_REX] = {4'h4, rex_w, regr[3], 1'b0, rmr[3]};
    end

endmodule

// File: hw/rtl/xenc_pack.sv
// Byte packer: squeezes the present header bytes together and appends the
// tail, giving the packed instruction and its length.
// Depends on xenc_pkg.
module xenc_pack (
    input  xenc_pkg::t_enc_layout i_layout,
    output xenc_pkg::t_enc_rsp    o_rsp
);
    import xenc_pkg::*;

    logic [127:0] hdr_buf;
    logic [2:0]   hdr_len;
    logic [63:0]  tail_mask;
    logic [127:0] tail_buf;

    always_comb begin
        hdr_buf = '0;
        hdr_len = 3'd0;
        for (int i = 0; i < HDR_SLOTS; i++) begin
            if (i_layout.hdr_vld[i]) begin
                hdr_buf = hdr_buf | ({120'd0, i_layout.hdr_byte[i]} << {hdr_len, 3'b000});
                hdr_len = hdr_len + 3'd1;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            tail_mask[j*8 +: 8] = {8{4'(j) < i_layout.tail_len}};
        end
    end

    assign tail_buf = {64'd0, i_layout.tail_val & tail_mask} << {hdr_len, 3'b000};

    assign o_rsp.bytes_low  = hdr_buf[63:0] | tail_buf[63:0];
    assign o_rsp.bytes_high = hdr_buf[127:64] | tail_buf[127:64];
    assign o_rsp.byte_count = {1'b0, hdr_len} + i_layout.tail_len;

endmodule

// File: hw/rtl/x86_64_instruction_encoder_core.sv
// x86-64 instruction encoder, top level: request register, encoding logic,
// result register. Depends on xenc_pkg, xenc_decode and xenc_pack.
//
// Usage:
//   The request channel (i_req_valid / o_req_ready / i_req) carries one word
//   per instruction: a form code, two register descriptors, an immediate and
//   a displacement. The result channel (o_rsp_valid / i_rsp_ready / o_rsp)
//   returns one word per request with the packed machine-code bytes, byte 0
//   in the low bits, and the number of valid bytes (1 to 10).
//   o_rsp_valid rises once an accepted request has moved from the request
//   register into the result register; that move waits while the result
//   register holds a word that is not taken. The encoding itself is
//   a single pass of decode and byte packing between the two registers, so
//   a new request is accepted every cycle while results are being taken.
//   When the receiver stalls, the result register holds its word and the
//   request register can still take one more request; only when both are
//   full does o_req_ready drop. Synchronous active-low reset empties both
//   stages; the block keeps no other state.
module x86_64_instruction_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  xenc_pkg::t_enc_req i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output xenc_pkg::t_enc_rsp o_rsp
);
    import xenc_pkg::*;

    t_enc_req    r_req;
    logic        r_req_vld;
    logic        n_req_vld;
    t_enc_rsp    r_rsp;
    logic        r_rsp_vld;
    logic        n_rsp_vld;
    t_enc_layout layout;
    t_enc_rsp    enc_rsp;
    logic        rsp_free;

    // The result register can take a new word when it is empty or its word
    // leaves this cycle; the request register then drains into it.
    assign rsp_free    = !r_rsp_vld || i_rsp_ready;
    assign o_req_ready = !r_req_vld || rsp_free;

    xenc_decode u_decode (
        .i_req    (r_req),
        .o_layout (layout)
    );

    xenc_pack u_pack (
        .i_layout (layout),
        .o_rsp    (enc_rsp)
    );

    always_comb begin
        n_req_vld = o_req_ready ? i_req_valid : r_req_vld;
        n_rsp_vld = rsp_free ? r_req_vld : r_rsp_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // Payload registers load only on a move into them.
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (rsp_free && r_req_vld) begin
            r_rsp <= enc_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.byte_count != 4'd0 && o_rsp.byte_count <= 4'd10))
        else $error("byte count out of range");

    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.byte_count <= 4'd8) |-> o_rsp.bytes_high == 64'd0)
        else $error("bytes beyond the count are not zero");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && rsp_free) |=> o_rsp_valid)
        else $error("pending request did not reach the result register");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_free |-> o_req_ready)
        else $error("request stalled while the result side is free");
`endif

endmodule

// File: tb/x86_64_instruction_encoder_core_tb.sv
// Testbench for the x86-64 instruction encoder: directed and random requests,
// with expected machine code computed by a predictor written in this file.
// Depends on xenc_pkg and x86_64_instruction_encoder_core.
`timescale 1ns / 1ps

module x86_64_instruction_encoder_core_tb;
    import xenc_pkg::*;

    // Register descriptor as it sits in reg_a and reg_b.
    typedef struct packed {
        logic       frc;
        logic [1:0] sz;
        logic       ext;
        logic [2:0] num;
    } t_reg_desc;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam t_reg_desc NO_REG = '0;

    // Prefixes, opcodes and ModRM fields used by the encoder.
    localparam logic [7:0] PFX_OPSIZE    = 8'h66;
    localparam logic [7:0] PFX_ADDRSIZE  = 8'h67;
    localparam logic [7:0] REX_BASE      = 8'h40;
    localparam logic [7:0] OP_CALL       = 8'hE8;
    localparam logic [7:0] OP_RET        = 8'hC3;
    localparam logic [7:0] OP_MOV_RIMM   = 8'hB0;
    localparam logic [7:0] OP_MOV_STORE  = 8'h88;
    localparam logic [7:0] OP_MOV_LOAD   = 8'h8A;
    localparam logic [7:0] OP_LEA        = 8'h8D;
    localparam logic [7:0] OP_SHIFT_IMM  = 8'hC0;
    localparam logic [7:0] OP_ADD_ACC    = 8'h04;
    localparam logic [7:0] OP_AND_ACC    = 8'h24;
    localparam logic [7:0] OP_GRP1       = 8'h80;
    localparam logic [7:0] OP_GRP1_IMM8  = 8'h83;
    localparam logic [7:0] OP_ADD_RR     = 8'h00;
    localparam logic [7:0] OP_OR_RR      = 8'h08;
    localparam logic [7:0] OP_PUSH_R     = 8'h50;
    localparam logic [7:0] OP_POP_R      = 8'h58;
    localparam logic [7:0] OP_PUSH_IMM8  = 8'h6A;
    localparam logic [7:0] OP_PUSH_IMM32 = 8'h68;
    localparam logic [7:0] OP_ESCAPE     = 8'h0F;
    localparam logic [7:0] OP_SYSCALL    = 8'h05;
    localparam logic [7:0] SIB_NO_INDEX  = 8'h24;
    localparam logic [1:0] MOD_INDIRECT  = 2'd0;
    localparam logic [1:0] MOD_DISP32    = 2'd2;
    localparam logic [1:0] MOD_REG       = 2'd3;
    localparam logic [2:0] RM_SIB        = 3'd4;
    localparam logic [2:0] DIGIT_ADD     = 3'd0;
    localparam logic [2:0] DIGIT_AND     = 3'd4;
    localparam logic [2:0] DIGIT_SHL     = 3'd4;

    localparam int MAX_IDLE      = 6;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 20;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    t_enc_req req_word;
    logic     rsp_valid;
    logic     rsp_ready;
    t_enc_rsp rsp_word;

    // Encodings of accepted words, oldest first, waiting for their result word.
    t_enc_rsp expected_encodings[$];
    int       error_count = 0;

    // Idling controls shared between the stimulus and the receiver.
    bit req_idle_on = 1'b1;
    bit rsp_idle_on = 1'b1;
    int rsp_hold_cycles = 0;

    // Scratch buffer of the predictor; only the checking process uses it.
    logic [7:0] code_bytes [16];
    logic [4:0] code_len;

    x86_64_instruction_encoder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_word),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run; a correct run finishes far earlier.
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: assembles the expected machine code for one request.
    // ------------------------------------------------------------------

    function automatic void emit(input logic [7:0] value);
        if (code_len < 5'd16) begin
            code_bytes[code_len[3:0]] = value;
            code_len++;
        end
    endfunction

    function automatic void emit_le(input logic [63:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            emit(value[8*i +: 8]);
    endfunction

    // The operand size prefix follows the operand register, the address size
    // prefix follows the base register of a memory operand.
    function automatic void emit_prefixes(input t_reg_desc base, input t_reg_desc opr);
        if (opr.sz == SZ_16)
            emit(PFX_OPSIZE);
        if (base.sz == SZ_32)
            emit(PFX_ADDRSIZE);
    endfunction

    // REX is needed for any extended register, a 64-bit operand or a forced REX.
    function automatic void emit_rex(input t_reg_desc rm_reg, input t_reg_desc reg_field,
                                     input t_reg_desc size_src);
        logic wide;
        wide = size_src.sz == SZ_64;
        if (rm_reg.ext || reg_field.ext || wide || rm_reg.frc || reg_field.frc
                || size_src.frc)
            emit(REX_BASE | {4'd0, wide, reg_field.ext, 1'b0, rm_reg.ext});
    endfunction

    function automatic void emit_modrm(input logic [1:0] mode, input logic [2:0] reg_bits,
                                       input logic [2:0] rm_bits);
        emit({mode, reg_bits, rm_bits});
    endfunction

    // Immediate as wide as the register; 64-bit registers take imm32 unless
    // the form allows a full 64-bit immediate.
    function automatic void emit_imm_by_size(input t_reg_desc r, input logic [63:0] value,
                                             input logic allow_imm64);
        case (r.sz)
            SZ_8:    emit_le(value, 1);
            SZ_16:   emit_le(value, 2);
            SZ_32:   emit_le(value, 4);
            default: emit_le(value, allow_imm64 ? 8 : 4);
        endcase
    endfunction

    function automatic void emit_mem_form(input logic [7:0] opcode, input t_reg_desc data,
                                          input t_reg_desc base, input logic [31:0] disp);
        emit_prefixes(base, data);
        emit_rex(base, data, data);
        emit(opcode);
        if (base.num == RM_SIB && disp == 32'd0) begin
            // A stack-pointer base with no displacement needs only the SIB byte.
            emit_modrm(MOD_INDIRECT, data.num, RM_SIB);
            emit(SIB_NO_INDEX);
        end else begin
            emit_modrm(MOD_DISP32, data.num, base.num);
            if (base.num == RM_SIB)
                emit(SIB_NO_INDEX);
            emit_le({32'd0, disp}, 4);
        end
    endfunction

    function automatic void emit_alu_imm(input logic [7:0] acc_opcode, input logic [2:0] digit,
                                         input t_reg_desc r, input logic [31:0] value);
        logic full;
        full = r.sz != SZ_8;
        emit_prefixes(NO_REG, r);
        emit_rex(r, NO_REG, r);
        if (r.num == 3'd0 && !r.ext) begin
            // Accumulator short form, no ModRM.
            emit(acc_opcode + {7'd0, full});
            emit_imm_by_size(r, {32'd0, value}, 1'b0);
        end else if (full && value < 32'd128) begin
            emit(OP_GRP1_IMM8);
            emit_modrm(MOD_REG, digit, r.num);
            emit_le({32'd0, value}, 1);
        end else begin
            emit(OP_GRP1 + {7'd0, full});
            emit_modrm(MOD_REG, digit, r.num);
            emit_imm_by_size(r, {32'd0, value}, 1'b0);
        end
    endfunction

    // Register to register: prefix and REX.W from the source, opcode width
    // from the destination.
    function automatic void emit_reg_reg(input logic [7:0] opcode, input t_reg_desc dst,
                                         input t_reg_desc src);
        emit_prefixes(NO_REG, src);
        emit_rex(dst, src, src);
        emit(opcode + {7'd0, dst.sz != SZ_8});
        emit_modrm(MOD_REG, src.num, dst.num);
    endfunction

    function automatic t_enc_rsp encode_instruction(input t_enc_req req);
        t_reg_desc   ra;
        t_reg_desc   rb;
        logic [31:0] imm32;
        logic        full_a;
        logic        full_b;
        t_enc_rsp    enc;
        ra = t_reg_desc'(req.reg_a);
        rb = t_reg_desc'(req.reg_b);
        imm32 = req.imm[31:0];
        full_a = ra.sz != SZ_8;
        full_b = rb.sz != SZ_8;
        code_len = '0;
        for (int i = 0; i < 16; i++)
            code_bytes[i] = 8'd0;
        case (t_cmd'(req.cmd))
            CMD_CALL: begin
                emit(OP_CALL);
                emit_le({32'd0, imm32}, 4);
            end
            CMD_RET: emit(OP_RET);
            CMD_MOV_IMM: begin
                emit_prefixes(NO_REG, ra);
                emit_rex(ra, NO_REG, ra);
                emit(OP_MOV_RIMM | {4'd0, full_a, ra.num});
                emit_imm_by_size(ra, req.imm, 1'b1);
            end
            CMD_MOV_RR: emit_reg_reg(OP_MOV_STORE, ra, rb);
            CMD_LOAD:   emit_mem_form(OP_MOV_LOAD + {7'd0, full_b}, rb, ra, req.disp);
            CMD_STORE:  emit_mem_form(OP_MOV_STORE + {7'd0, full_b}, rb, ra, req.disp);
            CMD_LEA:    emit_mem_form(OP_LEA, rb, ra, req.disp);
            CMD_SHL: begin
                emit_prefixes(NO_REG, ra);
                emit_rex(ra, NO_REG, ra);
                emit(OP_SHIFT_IMM + {7'd0, full_a});
                emit_modrm(MOD_REG, DIGIT_SHL, ra.num);
                emit_le(req.imm, 1);
            end
            CMD_ADD_IMM: emit_alu_imm(OP_ADD_ACC, DIGIT_ADD, ra, imm32);
            CMD_AND_IMM: emit_alu_imm(OP_AND_ACC, DIGIT_AND, ra, imm32);
            CMD_ADD_RR:  emit_reg_reg(OP_ADD_RR, ra, rb);
            CMD_OR_RR:   emit_reg_reg(OP_OR_RR, ra, rb);
            CMD_PUSH_R: begin
                emit_prefixes(NO_REG, ra);
                emit_rex(ra, NO_REG, NO_REG);
                emit(OP_PUSH_R | {5'd0, ra.num});
            end
            CMD_PUSH_IMM: begin
                if (imm32 < 32'd128) begin
                    emit(OP_PUSH_IMM8);
                    emit_le({32'd0, imm32}, 1);
                end else begin
                    emit(OP_PUSH_IMM32);
                    emit_le({32'd0, imm32}, 4);
                end
            end
            CMD_POP: begin
                emit_prefixes(NO_REG, ra);
                emit_rex(ra, NO_REG, NO_REG);
                emit(OP_POP_R | {5'd0, ra.num});
            end
            default: begin
                emit(OP_ESCAPE);
                emit(OP_SYSCALL);
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            enc.bytes_low[8*i +: 8]  = code_bytes[i];
            enc.bytes_high[8*i +: 8] = code_bytes[i + 8];
        end
        enc.byte_count = code_len[3:0];
        return enc;
    endfunction

    // ------------------------------------------------------------------
    // Checking: every result word is compared with the oldest expectation,
    // and every accepted request word adds one. All handshake signals are
    // read right after the edge, so they hold the values the block sampled.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk) begin
        t_enc_rsp want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_encodings.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result word with nothing expected, actual %h", $time,
                             rsp_word);
            end else begin
                want = expected_encodings.pop_front();
                if (want.bytes_low !== rsp_word.bytes_low)
                    report_mismatch("bytes_low", want.bytes_low, rsp_word.bytes_low);
                if (want.bytes_high !== rsp_word.bytes_high)
                    report_mismatch("bytes_high", want.bytes_high, rsp_word.bytes_high);
                if (want.byte_count !== rsp_word.byte_count)
                    report_mismatch("byte_count", {60'd0, want.byte_count},
                                    {60'd0, rsp_word.byte_count});
            end
        end
        if (rst_n && req_valid && req_ready)
            expected_encodings.push_back(encode_instruction(req_word));
    end

    // ------------------------------------------------------------------
    // Receiver: when rsp_idle_on is set, draws a stall before every result word, and on request
    // holds ready low for a long stretch so that both pipeline stages fill
    // and the block has to drop its request ready.
    // ------------------------------------------------------------------

    initial begin
        int stall;
        rsp_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (rsp_hold_cycles > 0) begin
                rsp_ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge clk);
                rsp_hold_cycles = 0;
            end
            stall = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic t_reg_desc reg_desc(input logic [2:0] num, input logic ext,
                                           input logic [1:0] sz, input logic frc);
        return {frc, sz, ext, num};
    endfunction

    function automatic t_enc_req make_req(input t_cmd cmd, input t_reg_desc ra,
                                          input t_reg_desc rb, input logic [63:0] imm,
                                          input logic [31:0] disp);
        t_enc_req req;
        req.cmd   = cmd;
        req.reg_a = ra;
        req.reg_b = rb;
        req.imm   = imm;
        req.disp  = disp;
        return req;
    endfunction

    // Random request; the low immediate word often sits near the 8-bit
    // immediate boundary, and memory forms often see a zero displacement.
    function automatic t_enc_req random_request();
        t_enc_req req;
        req.cmd   = 4'($urandom_range(0, 15));
        req.reg_a = 7'($urandom_range(0, 127));
        req.reg_b = 7'($urandom_range(0, 127));
        req.imm   = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: req.imm[31:0] = $urandom_range(0, 127);
            1: req.imm[31:0] = $urandom_range(120, 135);
            default: ;
        endcase
        req.disp = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        return req;
    endfunction

    // Sends one word. Called at a rising edge; returns at the edge where the
    // word was accepted, with valid still high so back-to-back words keep it.
    task automatic issue_request(input t_enc_req req);
        int gap;
        gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= req;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stops offering words until every expected result word has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_encodings.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Forms without register operands; call and push use only the low
    // immediate word, and push switches to imm32 from 128 upward.
    task automatic test_fixed_forms();
        issue_request(make_req(CMD_CALL, NO_REG, NO_REG, 64'hDEAD_BEEF_1234_5678, 32'd0));
        issue_request(make_req(CMD_RET, NO_REG, NO_REG, 64'd0, 32'd0));
        issue_request(make_req(CMD_SYSCALL, 7'h7F, 7'h7F, '1, '1));
        issue_request(make_req(CMD_PUSH_IMM, NO_REG, NO_REG, 64'hFFFF_FFFF_0000_007F, 32'd0));
        issue_request(make_req(CMD_PUSH_IMM, NO_REG, NO_REG, 64'h0000_0000_0000_0080, 32'd0));
    endtask

    // Register forms across all sizes, extended registers and forced REX.
    task automatic test_register_forms();
        issue_request(make_req(CMD_MOV_IMM, reg_desc(3'd7, 1'b1, SZ_64, 1'b0), NO_REG,
                               '1, 32'd0));
        issue_request(make_req(CMD_MOV_IMM, reg_desc(3'd3, 1'b0, SZ_16, 1'b0), NO_REG,
                               64'h0123_4567_89AB_CDEF, 32'd0));
        issue_request(make_req(CMD_MOV_IMM, reg_desc(3'd6, 1'b0, SZ_8, 1'b1), NO_REG,
                               64'h0000_0000_0000_00A5, 32'd0));
        issue_request(make_req(CMD_MOV_RR, reg_desc(3'd1, 1'b1, SZ_8, 1'b0),
                               reg_desc(3'd2, 1'b0, SZ_64, 1'b1), 64'd0, 32'd0));
        issue_request(make_req(CMD_SHL, reg_desc(3'd0, 1'b0, SZ_32, 1'b0), NO_REG,
                               64'hFFFF_FFFF_FFFF_FF1F, 32'd0));
        issue_request(make_req(CMD_PUSH_R, reg_desc(3'd4, 1'b1, SZ_64, 1'b0), NO_REG,
                               64'd0, 32'd0));
        issue_request(make_req(CMD_POP, reg_desc(3'd5, 1'b0, SZ_16, 1'b1), NO_REG,
                               64'd0, 32'd0));
    endtask

    // Arithmetic immediates: accumulator short form, the imm8 form at its
    // boundary, byte registers that must not use imm8, and the rr forms,
    // one of them with mixed operand sizes.
    task automatic test_alu_forms();
        issue_request(make_req(CMD_ADD_IMM, reg_desc(3'd0, 1'b0, SZ_8, 1'b0), NO_REG,
                               64'h0000_0000_0000_00FF, 32'd0));
        issue_request(make_req(CMD_ADD_IMM, reg_desc(3'd0, 1'b0, SZ_16, 1'b0), NO_REG,
                               64'h0000_0000_0000_1234, 32'd0));
        issue_request(make_req(CMD_AND_IMM, reg_desc(3'd0, 1'b0, SZ_64, 1'b1), NO_REG,
                               64'hFFFF_FFFF_8000_0001, 32'd0));
        issue_request(make_req(CMD_ADD_IMM, reg_desc(3'd0, 1'b1, SZ_64, 1'b0), NO_REG,
                               64'hFFFF_FFFF_0000_007F, 32'd0));
        issue_request(make_req(CMD_AND_IMM, reg_desc(3'd3, 1'b0, SZ_32, 1'b0), NO_REG,
                               64'h0000_0000_0000_0080, 32'd0));
        issue_request(make_req(CMD_AND_IMM, reg_desc(3'd2, 1'b0, SZ_8, 1'b0), NO_REG,
                               64'h0000_0000_0000_0005, 32'd0));
        issue_request(make_req(CMD_ADD_RR, reg_desc(3'd7, 1'b1, SZ_16, 1'b1),
                               reg_desc(3'd6, 1'b1, SZ_16, 1'b0), 64'd0, 32'd0));
        issue_request(make_req(CMD_OR_RR, reg_desc(3'd3, 1'b0, SZ_64, 1'b0),
                               reg_desc(3'd5, 1'b0, SZ_8, 1'b0), 64'd0, 32'd0));
    endtask

    // Memory operands: stack-pointer base with and without displacement,
    // a frame-pointer base with zero displacement, 32-bit addressing and
    // the byte-sized lea.
    task automatic test_memory_forms();
        issue_request(make_req(CMD_LOAD, reg_desc(3'd4, 1'b0, SZ_64, 1'b0),
                               reg_desc(3'd0, 1'b0, SZ_64, 1'b0), 64'd0, 32'd0));
        issue_request(make_req(CMD_STORE, reg_desc(3'd4, 1'b1, SZ_32, 1'b0),
                               reg_desc(3'd1, 1'b0, SZ_16, 1'b0), 64'd0, 32'h0000_0010));
        issue_request(make_req(CMD_LEA, reg_desc(3'd5, 1'b0, SZ_64, 1'b0),
                               reg_desc(3'd0, 1'b0, SZ_8, 1'b0), 64'd0, 32'd0));
        issue_request(make_req(CMD_LOAD, reg_desc(3'd5, 1'b1, SZ_64, 1'b1),
                               reg_desc(3'd7, 1'b1, SZ_64, 1'b1), 64'd0, '1));
        issue_request(make_req(CMD_STORE, reg_desc(3'd0, 1'b0, SZ_16, 1'b0),
                               reg_desc(3'd6, 1'b0, SZ_8, 1'b1), 64'd0, 32'h0000_0080));
        issue_request(make_req(CMD_LEA, reg_desc(3'd4, 1'b0, SZ_32, 1'b0),
                               reg_desc(3'd3, 1'b1, SZ_64, 1'b0), 64'd0, 32'd0));
    endtask

    // The receiver stops for a long stretch while words keep coming with no
    // gaps; the request side must stall once both stages are full.
    task automatic test_receiver_holdoff();
        drain_results();
        req_idle_on = 1'b0;
        rsp_hold_cycles = 60;
        repeat (24) issue_request(random_request());
        req_idle_on = 1'b1;
    endtask

    // Random words in chunks; each chunk picks which sides idle, so there
    // are stretches of full throughput as well. Now and then the sender
    // waits until the pipeline is empty.
    task automatic test_random_mix();
        int mode;
        for (int chunk = 0; chunk < 13; chunk++) begin
            mode = $urandom_range(0, 3);
            req_idle_on = mode[0];
            rsp_idle_on = mode[1];
            repeat (100) issue_request(random_request());
            if (chunk % 4 == 3)
                drain_results();
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_word  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fixed_forms();
        test_register_forms();
        test_alu_forms();
        test_memory_forms();
        test_receiver_holdoff();
        test_random_mix();

        // Let everything drain, then keep the clock running with no requests,
        // so that any stray result word would be caught.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/xenc_pkg.sv
hw/rtl/xenc_decode.sv
hw/rtl/xenc_pack.sv
hw/rtl/x86_64_instruction_encoder_core.sv
tb/x86_64_instruction_encoder_core_tb.sv
